[hw/rtl/sequential_list_engine_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define SLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Sizes, request codes and status codes of the ordered list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // word fields
    localparam int VAL_W     = 32;
    localparam int POS_W     = 6;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int OUT_IDX_W = 5;
    localparam int OUT_CNT_W = 6;

    localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_USED_W = VAL_W + OUT_IDX_W + OUT_CNT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_INSERT     = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_DUMP       = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_POS   = 2'd3
    } t_status;

endpackage

[hw/rtl/sequential_list_engine_core.sv]
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed 32-bit entries with push, pop, positional insert,
// dump and clear, kept in one synchronous single-port-read memory.
// ----------------------------------------------------------------------------
// One request at a time. A request that needs no memory move (push back,
// an insert at the tail, clear, rejected requests, code 7) goes from accept
// straight to its result. Insert at slot p below the tail moves the entries
// from the tail down to slot p up one slot, then writes the new value; push
// front is the slot 0 case. Pop back reads and captures the tail entry; pop
// front captures slot 0 and moves the rest down. A dump reads one entry and
// sends it out before it reads the next. The entry memory has one read and
// one write per cycle and registered read data, so every shift moves one
// entry per cycle. Output back-pressure adds its own wait. A result may sit
// in the output register while the next request is taken. Memory contents
// need no clearing after reset: only entries below the count are read.
`timescale 1ns / 1ps

module sequential_list_engine_core
    import sle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // value[31:0], position[37:32], zero
    input  logic [OP_W-1:0]       i_s_tuser,   // req_type[2:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // item_value[31:0], item_index[36:32],
                                               // item_count[42:37], zero
    output logic [ST_W-1:0]       o_m_tuser,   // status[1:0]
    output logic                  o_m_tlast
);

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DOWN,
        S_POP_RD,
        S_POP_CAP,
        S_DUMP,
        S_EMIT
    } t_state;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_rd;
    logic             r_rd_act;
    logic             r_wpend;
    logic [IDX_W-1:0] r_waddr;
    logic             r_cap;
    logic             r_dvalid;
    logic [IDX_W-1:0] r_ins;
    logic [VAL_W-1:0] r_val;
    t_status          r_res_status;
    logic [VAL_W-1:0] r_res_value;

    logic                 r_ovalid;
    t_status              r_o_status;
    logic [VAL_W-1:0]     r_o_value;
    logic [OUT_IDX_W-1:0] r_o_index;
    logic [OUT_CNT_W-1:0] r_o_count;
    logic                 r_o_last;

    logic             w_accept;
    logic             w_ofree;
    logic             w_oload;
    t_op              w_op;
    logic [VAL_W-1:0] w_value;
    logic [POS_W-1:0] w_pos;
    logic             w_full;
    logic             w_empty;
    logic             w_pos_ok;
    logic [IDX_W-1:0] w_slot;
    logic [CNT_W-1:0] w_count_m1;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_ofree    = !r_ovalid || i_m_tready;
    // output register takes a new word this cycle
    assign w_oload    = w_ofree && ((r_state == S_EMIT) || (r_state == S_DUMP && r_dvalid));

    assign w_op       = t_op'(i_s_tuser);
    assign w_value    = i_s_tdata[VAL_W-1:0];
    assign w_pos      = i_s_tdata[VAL_W +: POS_W];
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_pos_ok   = (w_pos != '0) &&
                        (CMP_W'(w_pos) <= (CMP_W'(r_count) + CMP_W'(1)));

    // 0-based target slot of an insert
    always_comb begin
        case (w_op)
            OP_PUSH_FRONT: w_slot = '0;
            OP_INSERT:     w_slot = IDX_W'(w_pos - POS_W'(1));
            default:       w_slot = r_count[IDX_W-1:0];
        endcase
    end

    // memory port control
    always_comb begin
        w_raddr = r_rd;
        w_we    = 1'b0;
        w_waddr = r_waddr;
        w_wdata = r_rdata;
        case (r_state)
            S_IDLE: begin
                // insert at the tail needs no shift
                if (w_accept && !w_full && (w_op == OP_PUSH_BACK ||
                    w_op == OP_PUSH_FRONT || (w_op == OP_INSERT && w_pos_ok)) &&
                    (CNT_W'(w_slot) == r_count)) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IDX_W-1:0];
                    w_wdata = w_value;
                end
            end
            S_UP, S_DOWN: w_we = r_wpend;
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_ins;
                w_wdata = r_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_act <= 1'b0;
            r_wpend  <= 1'b0;
            r_cap    <= 1'b0;
            r_dvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_value <= '0;
                        unique case (w_op) inside
                            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                                if (w_full) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_EMIT;
                                end else if (w_op == OP_INSERT && !w_pos_ok) begin
                                    r_res_status <= ST_POS;
                                    r_state      <= S_EMIT;
                                end else if (CNT_W'(w_slot) == r_count) begin
                                    r_res_status <= ST_OK;
                                    r_count      <= r_count + CNT_W'(1);
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_ins        <= w_slot;
                                    r_val        <= w_value;
                                    r_rd         <= w_count_m1[IDX_W-1:0];
                                    r_rd_act     <= 1'b1;
                                    r_wpend      <= 1'b0;
                                    r_state      <= S_UP;
                                end
                            end
                            OP_POP_BACK: begin
                                if (w_empty) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_rd         <= w_count_m1[IDX_W-1:0];
                                    r_state      <= S_POP_RD;
                                end
                            end
                            OP_POP_FRONT: begin
                                if (w_empty) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_rd         <= '0;
                                    r_rd_act     <= 1'b1;
                                    r_wpend      <= 1'b0;
                                    r_cap        <= 1'b0;
                                    r_state      <= S_DOWN;
                                end
                            end
                            OP_DUMP: begin
                                if (w_empty) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_rd         <= '0;
                                    r_dvalid     <= 1'b0;
                                    r_state      <= S_DUMP;
                                end
                            end
                            OP_CLEAR: begin
                                r_res_status <= ST_OK;
                                r_count      <= '0;
                                r_state      <= S_EMIT;
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_EMIT;
                            end
                        endcase
                    end
                end
                // move entries up one slot, from the tail down to the insert slot
                S_UP: begin
                    if (r_rd_act) begin
                        r_wpend <= 1'b1;
                        r_waddr <= r_rd + IDX_W'(1);
                        if (r_rd == r_ins) begin
                            r_rd_act <= 1'b0;
                        end else begin
                            r_rd <= r_rd - IDX_W'(1);
                        end
                    end else begin
                        r_wpend <= 1'b0;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_EMIT;
                end
                // slot 0 is captured as the removed value, the rest move down
                S_DOWN: begin
                    if (r_cap) begin
                        r_res_value <= r_rdata;
                        r_cap       <= 1'b0;
                    end
                    if (r_rd_act) begin
                        if (r_rd == '0) begin
                            r_cap   <= 1'b1;
                            r_wpend <= 1'b0;
                        end else begin
                            r_wpend <= 1'b1;
                            r_waddr <= r_rd - IDX_W'(1);
                        end
                        if (CNT_W'(r_rd) == w_count_m1) begin
                            r_rd_act <= 1'b0;
                        end else begin
                            r_rd <= r_rd + IDX_W'(1);
                        end
                    end else begin
                        r_wpend <= 1'b0;
                        r_count <= w_count_m1;
                        r_state <= S_EMIT;
                    end
                end
                S_POP_RD: r_state <= S_POP_CAP;
                S_POP_CAP: begin
                    r_res_value <= r_rdata;
                    r_count     <= w_count_m1;
                    r_state     <= S_EMIT;
                end
                S_DUMP: begin
                    if (r_dvalid && w_ofree) begin
                        r_o_status <= ST_OK;
                        r_o_value  <= r_rdata;
                        r_o_index  <= OUT_IDX_W'(r_rd);
                        r_o_count  <= OUT_CNT_W'(r_count);
                        r_o_last   <= (CNT_W'(r_rd) == w_count_m1);
                        r_dvalid   <= 1'b0;
                        if (CNT_W'(r_rd) == w_count_m1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd <= r_rd + IDX_W'(1);
                        end
                    end else if (!r_dvalid) begin
                        r_dvalid <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_ofree) begin
                        r_o_status <= r_res_status;
                        r_o_value  <= r_res_value;
                        r_o_index  <= '0;
                        r_o_count  <= OUT_CNT_W'(r_count);
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), r_o_count, r_o_index, r_o_value};
    assign o_m_tuser  = r_o_status;
    assign o_m_tlast  = r_o_last;

endmodule

[hw/rtl/sle_checker.sv]
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sequential_list_engine_core_defines.svh"

module sle_checker
    import sle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [ST_W-1:0]       i_m_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_m_tlast
);

    // a stalled word holds
    `SLE_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "output word changed under stall")

    // one request in flight
    `SLE_ASSERT_NEXT(a_one_req, i_s_tvalid && i_s_tready, !i_s_tready, "request taken while busy")

    // rejected requests give a single zero-valued word
    `SLE_ASSERT_IMPL(a_err_word, i_m_tvalid && (i_m_tuser != ST_OK), i_m_tlast && (i_m_tdata[VAL_W-1:0] == '0), "error word not final or not zero")

    // count never exceeds capacity
    `SLE_ASSERT_IMPL(a_count_cap, i_m_tvalid, i_m_tdata[VAL_W+OUT_IDX_W +: OUT_CNT_W] <= OUT_CNT_W'(CAPACITY), "count above capacity")

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tlast  (o_m_tlast)
);
